// File: rtl/core/pdtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pdtm_pkg: shared types and constants of the tone and clip mixer
// Holds the action and status codes, register indexes, the item structs and
// the sine ROM function.
// -----------------------------------------------------------------------------
package pdtm_pkg;

  localparam int unsigned Voices          = 20;
  localparam int unsigned VoiceIdxW       = (Voices > 1) ? $clog2(Voices) : 1;
  localparam int unsigned SineTableBits   = 10;
  localparam int unsigned ClipMemoryWords = 65536;
  localparam int unsigned ClipAddrW       = $clog2(ClipMemoryWords);
  localparam int unsigned QuarterBits     = SineTableBits - 2;
  localparam int unsigned QuarterSize     = 1 << QuarterBits;

  localparam logic [23:0] DecayReset = 24'd1678;
  localparam logic [31:0] GlideReset = 32'd9739;
  localparam logic [15:0] GainReset  = 16'd13107;

  localparam logic signed [20:0] MixMax = 21'sd1048575;
  localparam logic signed [20:0] MixMin = -21'sd1048576;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_TONE  = 2'd1,
    ACT_CLIP  = 2'd2,
    ACT_WRITE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_SAMPLE  = 2'd0,
    ST_STARTED = 2'd1,
    ST_FULL    = 2'd2,
    ST_WRITTEN = 2'd3
  } status_e;

  localparam logic [1:0] RegDecay = 2'd0;
  localparam logic [1:0] RegGlide = 2'd1;
  localparam logic [1:0] RegGain  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        phase_step;
    logic [23:0]        start_amplitude;
    logic               glide_enable;
    logic [15:0]        clip_start;
    logic [16:0]        clip_length;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_value;
  } item_t;

  typedef struct packed {
    logic signed [20:0] mixed_sample;
    logic [1:0]         status;
  } result_t;

  // Quarter-wave magnitudes, one entry per position including the peak.
  typedef logic [QuarterSize:0][14:0] quarter_tab_t;

  // Polynomial quarter-wave magnitude at position r of the quadrant.
  function automatic logic [14:0] quarter_entry(input int unsigned r);
    logic [63:0] x, x2, t, y, s;
    x  = 64'(r) << (16 - QuarterBits);
    x2 = (x * x) >> 16;
    t  = (64'd4640 * x2) >> 16;
    t  = 64'd42047 - t;
    t  = (t * x2) >> 16;
    t  = 64'd102944 - t;
    y  = (t * x) >> 16;
    s  = (y * 64'd32767 + 64'd32768) >> 16;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[14:0];
  endfunction

  function automatic quarter_tab_t build_quarter();
    quarter_tab_t tab;
    for (int unsigned r = 0; r <= QuarterSize; r++) begin
      tab[r] = quarter_entry(r);
    end
    return tab;
  endfunction

  localparam quarter_tab_t QuarterTab = build_quarter();

  // Sine ROM entry in Q1.15: the quadrant mirrors and signs the quarter wave.
  function automatic logic signed [15:0] sine_rom(input logic [SineTableBits-1:0] idx);
    logic [1:0]             quad;
    logic [QuarterBits-1:0] r0;
    logic [QuarterBits:0]   r;
    logic [15:0]            mag;
    quad = idx[SineTableBits-1 -: 2];
    r0   = idx[QuarterBits-1:0];
    r    = quad[0] ? (QuarterBits+1)'(QuarterSize) - {1'b0, r0} : {1'b0, r0};
    mag  = {1'b0, QuarterTab[r]};
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pdtm_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pdtm_stream_if: valid/ready channel
// Generic stream channel carrying one payload beat per handshake.
// -----------------------------------------------------------------------------
interface pdtm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Configuration write channel.
interface pdtm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pdtm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pdtm_front: input stage and command queue
// Accepts input beats and holds them in a two-entry queue for the engine.
// -----------------------------------------------------------------------------
module pdtm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  pdtm_pkg::item_t     in_item_i,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  output pdtm_pkg::item_t     cmd_item_o
);
  import pdtm_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_item_o  = mem_q[rptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_item_i;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2) else $error("queue count lost");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: rtl/core/pdtm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pdtm_engine: voice table sequencer
// Executes commands: voice starts, sample writes and ticks that walk the
// voice table one voice per cycle through a short arithmetic pipeline.
// -----------------------------------------------------------------------------
module pdtm_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  pdtm_pkg::item_t     cmd_item_i,
  input  wire logic           cfg_valid_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output pdtm_pkg::result_t   res_o
);
  import pdtm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [VoiceIdxW-1:0] LastVoice = VoiceIdxW'(Voices - 1);
  localparam int unsigned DrainCycles = 3;

  // Configuration registers.
  logic [23:0] decay_q;
  logic [31:0] glide_q;
  logic [15:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DecayReset;
      glide_q <= GlideReset;
      gain_q  <= GainReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDecay: decay_q <= cfg_data_i[23:0];
        RegGlide: glide_q <= cfg_data_i;
        RegGain:  gain_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Voice table.
  logic [Voices-1:0] valid_q;
  logic [Voices-1:0] is_clip_q;
  logic [Voices-1:0] glide_en_q;
  logic [31:0]       phase_q  [Voices];
  logic [31:0]       step_q   [Voices];
  logic [23:0]       level_q  [Voices];
  logic [15:0]       pos_q    [Voices];
  logic [16:0]       remain_q [Voices];

  logic [15:0] clip_mem [ClipMemoryWords];

  logic [2:0]           state_q;
  logic [VoiceIdxW-1:0] idx_q;
  logic [1:0]           drain_q;
  logic signed [20:0]   acc_q;
  result_t              res_q;

  // Lowest free slot.
  logic                 free_found;
  logic [VoiceIdxW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Voices - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = VoiceIdxW'(i);
      end
    end
  end

  // Stage 0 per voice update.
  logic        s0_go;
  logic [23:0] lvl_new;
  logic [31:0] step_new;
  assign s0_go = (state_q == S_SCAN) && valid_q[idx_q];
  always_comb begin
    lvl_new  = (level_q[idx_q] > decay_q) ? level_q[idx_q] - decay_q : 24'd0;
    step_new = step_q[idx_q];
    if (glide_en_q[idx_q]) begin
      step_new = (step_q[idx_q] > glide_q) ? step_q[idx_q] - glide_q : 32'd0;
    end
  end

  // Pipeline registers: stage 1 holds sine and level, stage 2 the product.
  logic               p1_v_q, p1_clip_q;
  logic signed [15:0] p1_sine_q;
  logic [23:0]        p1_lvl_q;
  logic               p2_v_q, p2_clip_q, p2_neg_q;
  logic [39:0]        p2_prod_q;
  logic [23:0]        p2_lvl_q;
  logic signed [15:0] p2_clip_val_q;
  logic [15:0]        clip_rd_q;

  logic [15:0] sine_mag;
  assign sine_mag = p1_sine_q[15] ? 16'(-p1_sine_q) : p1_sine_q;

  logic [63:0] full_prod;
  logic [23:0] mag;
  logic signed [21:0] acc_sum;
  assign full_prod = 64'(p2_prod_q) * 64'(p2_lvl_q);
  assign mag = full_prod[63:40];

  always_comb begin
    acc_sum = 22'(acc_q);
    if (p2_v_q) begin
      if (p2_clip_q) acc_sum = 22'(acc_q) + 22'(p2_clip_val_q);
      else if (p2_neg_q) acc_sum = 22'(acc_q) - 22'($signed({1'b0, mag}));
      else acc_sum = 22'(acc_q) + 22'($signed({1'b0, mag}));
    end
  end

  // Saturated tick result after the pipeline drains.
  logic signed [20:0] acc_sat;
  always_comb begin
    if (acc_sum > 22'(MixMax)) acc_sat = MixMax;
    else if (acc_sum < 22'(MixMin)) acc_sat = MixMin;
    else acc_sat = 21'(acc_sum);
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  logic cmd_go;
  assign cmd_go = cmd_valid_i && cmd_ready_o;

  // Clip memory port.
  always_ff @(posedge clk_i) begin
    if (cmd_go && action_e'(cmd_item_i.action) == ACT_WRITE) begin
      clip_mem[cmd_item_i.sample_address[ClipAddrW-1:0]] <= cmd_item_i.sample_value;
    end
    clip_rd_q <= clip_mem[pos_q[idx_q][ClipAddrW-1:0]];
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    p1_clip_q     <= is_clip_q[idx_q];
    p1_sine_q     <= sine_rom(phase_q[idx_q][31 -: SineTableBits]);
    p1_lvl_q      <= lvl_new;
    p2_clip_q     <= p1_clip_q;
    p2_neg_q      <= p1_sine_q[15];
    p2_prod_q     <= 40'(sine_mag) * 40'(gain_q);
    p2_lvl_q      <= p1_lvl_q;
    p2_clip_val_q <= clip_rd_q;
  end

  // Sequencer and voice table updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      drain_q    <= '0;
      acc_q      <= '0;
      res_q      <= '0;
      valid_q    <= '0;
      is_clip_q  <= '0;
      glide_en_q <= '0;
      p1_v_q     <= 1'b0;
      p2_v_q     <= 1'b0;
      for (int i = 0; i < Voices; i++) begin
        phase_q[i]  <= '0;
        step_q[i]   <= '0;
        level_q[i]  <= '0;
        pos_q[i]    <= '0;
        remain_q[i] <= '0;
      end
    end else begin
      p1_v_q <= s0_go;
      p2_v_q <= p1_v_q;
      if (state_q != S_IDLE) acc_q <= acc_sum[20:0];
      case (state_q)
        S_IDLE: begin
          if (cmd_go) begin
            state_q <= S_OUT;
            res_q.mixed_sample <= '0;
            case (action_e'(cmd_item_i.action))
              ACT_TICK: begin
                state_q <= S_SCAN;
                idx_q   <= '0;
                acc_q   <= '0;
              end
              ACT_WRITE: res_q.status <= ST_WRITTEN;
              default: begin
                if (!free_found) begin
                  res_q.status <= ST_FULL;
                end else begin
                  res_q.status        <= ST_STARTED;
                  valid_q[free_idx]   <= 1'b1;
                  phase_q[free_idx]   <= '0;
                  if (action_e'(cmd_item_i.action) == ACT_TONE) begin
                    is_clip_q[free_idx]  <= 1'b0;
                    step_q[free_idx]     <= cmd_item_i.phase_step;
                    level_q[free_idx]    <= cmd_item_i.start_amplitude;
                    glide_en_q[free_idx] <= cmd_item_i.glide_enable;
                    pos_q[free_idx]      <= '0;
                    remain_q[free_idx]   <= '0;
                  end else begin
                    is_clip_q[free_idx]  <= 1'b1;
                    step_q[free_idx]     <= '0;
                    level_q[free_idx]    <= '0;
                    glide_en_q[free_idx] <= 1'b0;
                    pos_q[free_idx]      <= cmd_item_i.clip_start;
                    remain_q[free_idx]   <= (cmd_item_i.clip_length == 17'd0)
                                            ? 17'd1 : cmd_item_i.clip_length;
                  end
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (s0_go) begin
            level_q[idx_q] <= lvl_new;
            if (is_clip_q[idx_q]) begin
              pos_q[idx_q]    <= pos_q[idx_q] + 16'd1;
              remain_q[idx_q] <= remain_q[idx_q] - 17'd1;
              if (remain_q[idx_q] <= 17'd1) valid_q[idx_q] <= 1'b0;
            end else begin
              step_q[idx_q]  <= step_new;
              phase_q[idx_q] <= phase_q[idx_q] + step_new;
              if (lvl_new == 24'd0) valid_q[idx_q] <= 1'b0;
            end
          end
          if (idx_q == LastVoice) begin
            state_q <= S_DRAIN;
            drain_q <= '0;
          end else begin
            idx_q <= idx_q + VoiceIdxW'(1);
          end
        end
        S_DRAIN: begin
          drain_q <= drain_q + 2'd1;
          if (drain_q == 2'(DrainCycles - 1)) begin
            state_q            <= S_OUT;
            res_q.mixed_sample <= acc_sat;
            res_q.status       <= ST_SAMPLE;
          end
        end
        S_OUT: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE || state_q == S_SCAN || state_q == S_DRAIN || state_q == S_OUT)
    else $error("bad state code");
  a_tick_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN && drain_q == 2'(DrainCycles - 1) |=> res_q.status == ST_SAMPLE)
    else $error("tick did not report a sample");
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !p2_v_q) else $error("voice pipeline busy while idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> $stable(res_q)) else $error("result changed");

endmodule
`default_nettype wire

// File: rtl/core/polyphonic_decaying_tone_and_clip_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// polyphonic_decaying_tone_and_clip_mixer: tone and clip voice mixer
// Mixes up to twenty decaying sine tone voices and memory clip voices.
// -----------------------------------------------------------------------------
// Usage:
// Commands arrive as beats on in_if: tick, start tone, start clip or write a
// clip sample. Every command gives exactly one result beat on out_if with the
// mix (ticks only) and a status code. Registers are to be written on cfg_if
// only while the block is idle; the block itself does not enforce this. The
// write is taken in the cycle it is presented. A two-entry command queue
// decouples the input from the voice engine. Starts and sample writes are
// executed in the idle state, then the result is presented. A tick walks
// the voice table one voice per cycle, then drains a three-stage multiply
// pipeline before the result is presented.
// The engine works one command at a time and the result register holds its
// beat until out_if is ready; meanwhile the queue takes commands until full.
// Reset clears every voice and restores the register defaults; the clip
// memory holds no defined contents until it is written.
// -----------------------------------------------------------------------------
module polyphonic_decaying_tone_and_clip_mixer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pdtm_stream_if.sink   in_if,
  pdtm_stream_if.source out_if,
  pdtm_cfg_if.sink      cfg_if
);
  import pdtm_pkg::*;

  logic  cmd_valid, cmd_ready;
  item_t cmd_item;

  assign cfg_if.ready = 1'b1;

  pdtm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_item_i   (in_if.payload),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_item_o  (cmd_item)
  );

  pdtm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_item_i  (cmd_item),
    .cfg_valid_i (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .res_valid_o (out_if.valid),
    .res_ready_i (out_if.ready),
    .res_o       (out_if.payload)
  );

endmodule
`default_nettype wire
